// ----- rtl/core/clidm_pkg.sv -----
// ----------------------------------------------------------------------------
// clidm_pkg
// Shared types and constants for the cpu load idle delta monitor.
// ----------------------------------------------------------------------------
package clidm_pkg;

  // default width of the free-running counters
  localparam int unsigned CounterBits = 32;
  // width of a percent value (0..100)
  localparam int unsigned PctBits = 7;
  // width of the wrapping sample counters
  localparam int unsigned TallyBits = 32;
  // reset value of the peak limit register
  localparam logic [PctBits-1:0] PeakLimitRst = 7'd100;

  // function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_PEAK_CLR = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_SNAP = 3'd1;
  localparam logic [2:0] ST_BASELINE = 3'd2;
  localparam logic [2:0] ST_ZERO = 3'd3;
  localparam logic [2:0] ST_ANOMALY = 3'd4;
  localparam logic [2:0] ST_PEAK_RESET = 3'd5;

  typedef struct packed {
    logic        func;
    logic        snapshot_ok;
    logic [31:0] total_count;
    logic [31:0] idle_count;
  } in_t;

  typedef struct packed {
    logic [PctBits-1:0]   load_pct;
    logic [2:0]           status;
    logic [PctBits-1:0]   peak_pct;
    logic [PctBits-1:0]   last_window_pct;
    logic                 peak_ok;
    logic [TallyBits-1:0] ok_total;
    logic [TallyBits-1:0] skip_total;
  } out_t;

endpackage

// ----- rtl/core/clidm_sub.sv -----
// ----------------------------------------------------------------------------
// clidm_sub
// Shared subtract and compare unit: a - b with borrow out.
// ----------------------------------------------------------------------------
module clidm_sub #(
  parameter int unsigned Width = 39
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic [Width-1:0] diff_o,
  output logic             borrow_o
);

  logic [Width:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[Width-1:0];
  assign borrow_o = full[Width];

endmodule

// ----- rtl/core/clidm_core.sv -----
// ----------------------------------------------------------------------------
// clidm_core
// Sequencer and state of the load monitor. Deltas, the idle/total compare
// and a 7-step restoring division all run through one shared subtractor.
// ----------------------------------------------------------------------------
module clidm_core #(
  parameter int unsigned CounterBits = clidm_pkg::CounterBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  clidm_pkg::in_t                in_data_i,
  input  logic [clidm_pkg::PctBits-1:0] limit_i,
  output logic                          fin_valid_o,
  input  logic                          fin_ready_i,
  output clidm_pkg::out_t               fin_data_o
);

  localparam int unsigned PB = clidm_pkg::PctBits;
  localparam int unsigned TB = clidm_pkg::TallyBits;
  // remainder must hold 100 * busy
  localparam int unsigned WW = CounterBits + PB;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DT    = 3'd1;
  localparam logic [2:0] S_DI    = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] status_q, status_d;
  logic [2:0] bit_q, bit_d;
  logic [PB-1:0] quo_q, quo_d;
  logic [WW-1:0] rem_q, rem_d;
  logic [CounterBits-1:0] dt_q, dt_d;
  logic [CounterBits-1:0] tot_q, tot_d;
  logic [CounterBits-1:0] idl_q, idl_d;

  logic                   base_q, base_d;
  logic [CounterBits-1:0] prev_tot_q, prev_tot_d;
  logic [CounterBits-1:0] prev_idl_q, prev_idl_d;
  logic [PB-1:0]          window_q, window_d;
  logic [PB-1:0]          peak_q, peak_d;
  logic [TB-1:0]          good_q, good_d;
  logic [TB-1:0]          skip_q, skip_d;

  logic [WW-1:0] sub_a, sub_b, sub_diff;
  logic          sub_borrow;
  logic          accept;
  logic          commit;
  logic [PB-1:0] load_c;
  logic [PB-1:0] load_out;

  clidm_sub #(.Width(WW)) u_sub (
    .a_i     (sub_a),
    .b_i     (sub_b),
    .diff_o  (sub_diff),
    .borrow_o(sub_borrow)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign fin_valid_o = (state_q == S_FIN);
  assign commit      = fin_valid_o && fin_ready_i;

  // operand select for the shared subtractor
  always_comb begin
    sub_a = WW'(tot_q);
    sub_b = WW'(prev_tot_q);
    case (state_q)
      S_DI: begin
        sub_a = WW'(idl_q);
        sub_b = WW'(prev_idl_q);
      end
      S_CMP: begin
        sub_a = WW'(dt_q);
        sub_b = rem_q;
      end
      S_DIV: begin
        sub_a = rem_q;
        sub_b = WW'(dt_q) << bit_q;
      end
      default: begin
        sub_a = WW'(tot_q);
        sub_b = WW'(prev_tot_q);
      end
    endcase
  end

  // ceiling: bump the floor quotient when a remainder is left
  assign load_c   = quo_q + PB'(rem_q != '0);
  assign load_out = (status_q == clidm_pkg::ST_OK) ? load_c : '0;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    bit_d    = bit_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dt_d     = dt_q;
    tot_d    = tot_q;
    idl_d    = idl_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          tot_d   = CounterBits'(in_data_i.total_count);
          idl_d   = CounterBits'(in_data_i.idle_count);
          state_d = S_FIN;
          if (in_data_i.func == clidm_pkg::FUNC_PEAK_CLR) begin
            status_d = clidm_pkg::ST_PEAK_RESET;
          end else if (!in_data_i.snapshot_ok) begin
            status_d = clidm_pkg::ST_NO_SNAP;
          end else if (!base_q) begin
            status_d = clidm_pkg::ST_BASELINE;
          end else begin
            state_d = S_DT;
          end
        end
      end
      S_DT: begin
        dt_d    = sub_diff[CounterBits-1:0];
        state_d = S_DI;
      end
      S_DI: begin
        if (dt_q == '0) begin
          status_d = clidm_pkg::ST_ZERO;
          state_d  = S_FIN;
        end else begin
          rem_d   = WW'(sub_diff[CounterBits-1:0]);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        // borrow here means idle delta exceeds total delta
        if (sub_borrow) begin
          status_d = clidm_pkg::ST_ANOMALY;
          state_d  = S_FIN;
        end else begin
          rem_d   = WW'(sub_diff[CounterBits-1:0]);
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        // 100 * busy = 64b + 32b + 4b
        rem_d   = (rem_q << 6) + (rem_q << 5) + (rem_q << 2);
        quo_d   = '0;
        bit_d   = 3'(PB - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!sub_borrow) begin
          rem_d        = sub_diff;
          quo_d[bit_q] = 1'b1;
        end
        if (bit_q == '0) begin
          status_d = clidm_pkg::ST_OK;
          state_d  = S_FIN;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      S_FIN: begin
        if (fin_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // monitor state, updated when the result is handed over
  always_comb begin
    base_d     = base_q;
    prev_tot_d = prev_tot_q;
    prev_idl_d = prev_idl_q;
    window_d   = window_q;
    peak_d     = peak_q;
    good_d     = good_q;
    skip_d     = skip_q;
    case (status_q)
      clidm_pkg::ST_PEAK_RESET: begin
        peak_d   = '0;
        window_d = '0;
      end
      clidm_pkg::ST_NO_SNAP, clidm_pkg::ST_ZERO: begin
        skip_d = skip_q + 1'b1;
      end
      clidm_pkg::ST_BASELINE, clidm_pkg::ST_ANOMALY: begin
        base_d     = 1'b1;
        prev_tot_d = tot_q;
        prev_idl_d = idl_q;
        skip_d     = skip_q + 1'b1;
      end
      clidm_pkg::ST_OK: begin
        prev_tot_d = tot_q;
        prev_idl_d = idl_q;
        window_d   = load_c;
        good_d     = good_q + 1'b1;
        if (load_c > peak_q) begin
          peak_d = load_c;
        end
      end
      default: begin
        skip_d = skip_q;
      end
    endcase
  end

  assign fin_data_o.load_pct        = load_out;
  assign fin_data_o.status          = status_q;
  assign fin_data_o.peak_pct        = peak_d;
  assign fin_data_o.last_window_pct = window_d;
  assign fin_data_o.peak_ok         = (peak_d <= limit_i);
  assign fin_data_o.ok_total        = good_d;
  assign fin_data_o.skip_total      = skip_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      base_q     <= 1'b0;
      prev_tot_q <= '0;
      prev_idl_q <= '0;
      window_q   <= '0;
      peak_q     <= '0;
      good_q     <= '0;
      skip_q     <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        base_q     <= base_d;
        prev_tot_q <= prev_tot_d;
        prev_idl_q <= prev_idl_d;
        window_q   <= window_d;
        peak_q     <= peak_d;
        good_q     <= good_d;
        skip_q     <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    bit_q    <= bit_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    dt_q     <= dt_d;
    tot_q    <= tot_d;
    idl_q    <= idl_d;
  end

endmodule

// ----- rtl/core/cpu_load_idle_delta_monitor.sv -----
// ----------------------------------------------------------------------------
// cpu_load_idle_delta_monitor
// Busy percent from free-running total and idle run-time counters.
// ----------------------------------------------------------------------------
// Each request carries the current total and idle counter values (or a peak
// clear) and returns exactly one result. A sample request runs two
// wrap-around deltas and the idle/total compare on one shared subtractor of
// COUNTER_BITS+7 bits, then a shift-add scale by 100 and a 7-step restoring
// division on the same subtractor. Peak clear, missing snapshot and baseline
// requests go straight to the result; a zero-elapsed sample stops after the
// deltas and an anomaly after the compare. in_ready_o is high only
// while the sequencer is idle; the result sits in an output register, so a
// new request can be taken while an earlier result waits. The peak limit
// register may be written at any idle time and takes effect on the next
// result.
module cpu_load_idle_delta_monitor #(
  parameter int unsigned COUNTER_BITS = clidm_pkg::CounterBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  clidm_pkg::in_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output clidm_pkg::out_t               out_data_o,
  input  logic                          cfg_we_i,
  input  logic [clidm_pkg::PctBits-1:0] cfg_data_i
);

  logic [clidm_pkg::PctBits-1:0] limit_q;
  logic                          fin_valid;
  logic                          fin_ready;
  clidm_pkg::out_t               fin_data;
  logic                          out_valid_q;
  clidm_pkg::out_t               out_data_q;

  clidm_core #(.CounterBits(COUNTER_BITS)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .limit_i    (limit_q),
    .fin_valid_o(fin_valid),
    .fin_ready_i(fin_ready),
    .fin_data_o (fin_data)
  );

  // output slot is free when empty or being drained
  assign fin_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= clidm_pkg::PeakLimitRst;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (fin_ready) begin
        out_valid_q <= fin_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid && fin_ready) begin
      out_data_q <= fin_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_skip_zero_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != clidm_pkg::ST_OK) |-> out_data_o.load_pct == '0)
    else $error("load_pct nonzero on a skipped request");

  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.load_pct <= 7'd100)
    else $error("load_pct above 100");

  a_peak_ge_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.peak_pct >= out_data_o.last_window_pct)
    else $error("peak below last window");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer took a request without leaving idle");
`endif

endmodule

// ----- dv/clidm_load_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clidm_load_checker
// Watches the request, result and limit ports of the cpu load monitor. It
// predicts each result from its own copy of the baselines, percents and
// tallies, and compares every returned result field by field in order.
// ----------------------------------------------------------------------------
module clidm_load_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  clidm_pkg::in_t                in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  clidm_pkg::out_t               out_data_i,
  input  logic                          cfg_we_i,
  input  logic [clidm_pkg::PctBits-1:0] cfg_data_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   outstanding_o,
  output int unsigned                   checked_cnt_o,
  output logic [5:0]                    status_seen_o
);

  logic                            have_base;
  logic [31:0]                     base_total;
  logic [31:0]                     base_idle;
  logic [clidm_pkg::PctBits-1:0]   window_hold;
  logic [clidm_pkg::PctBits-1:0]   peak_hold;
  logic [clidm_pkg::PctBits-1:0]   peak_cap;
  logic [clidm_pkg::TallyBits-1:0] good_tally;
  logic [clidm_pkg::TallyBits-1:0] skip_tally;
  clidm_pkg::out_t                 reports_due[$];
  int unsigned                     fails;
  int unsigned                     checked;
  logic [7:0]                      seen;

  // updates the load state for one request and returns the result it causes
  function automatic clidm_pkg::out_t predict_report(clidm_pkg::in_t req);
    clidm_pkg::out_t rep;
    logic [31:0]     d_total;
    logic [31:0]     d_idle;
    logic [38:0]     span;
    logic [38:0]     busy_x100;
    rep = '0;
    rep.status = clidm_pkg::ST_OK;
    if (req.func == clidm_pkg::FUNC_PEAK_CLR) begin
      peak_hold = '0;
      window_hold = '0;
      rep.status = clidm_pkg::ST_PEAK_RESET;
    end else if (!req.snapshot_ok) begin
      skip_tally++;
      rep.status = clidm_pkg::ST_NO_SNAP;
    end else if (!have_base) begin
      base_total = req.total_count;
      base_idle = req.idle_count;
      have_base = 1'b1;
      skip_tally++;
      rep.status = clidm_pkg::ST_BASELINE;
    end else begin
      d_total = req.total_count - base_total;
      if (d_total == '0) begin
        skip_tally++;
        rep.status = clidm_pkg::ST_ZERO;
      end else begin
        d_idle = req.idle_count - base_idle;
        base_total = req.total_count;
        base_idle = req.idle_count;
        if (d_idle > d_total) begin
          skip_tally++;
          rep.status = clidm_pkg::ST_ANOMALY;
        end else begin
          // ceiling of 100 * busy / total, wide enough not to overflow
          span = {7'd0, d_total};
          busy_x100 = {7'd0, d_total - d_idle} * 39'd100;
          rep.load_pct = clidm_pkg::PctBits'(busy_x100 / span +
                                             39'((busy_x100 % span) != 0));
          window_hold = rep.load_pct;
          good_tally++;
          if (rep.load_pct > peak_hold) begin
            peak_hold = rep.load_pct;
          end
        end
      end
    end
    rep.peak_pct = peak_hold;
    rep.last_window_pct = window_hold;
    rep.peak_ok = (peak_hold <= peak_cap);
    rep.ok_total = good_tally;
    rep.skip_total = skip_tally;
    return rep;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    clidm_pkg::out_t want;
    if (!rst_ni) begin
      have_base = 1'b0;
      base_total = '0;
      base_idle = '0;
      window_hold = '0;
      peak_hold = '0;
      peak_cap = clidm_pkg::PeakLimitRst;
      good_tally = '0;
      skip_tally = '0;
      reports_due.delete();
      fails = 0;
      checked = 0;
      seen = '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (reports_due.size() == 0) begin
          $error("result returned with no request outstanding");
          fails++;
        end else begin
          want = reports_due.pop_front();
          checked++;
          check_field("load_pct", 32'(want.load_pct), 32'(out_data_i.load_pct));
          check_field("status", 32'(want.status), 32'(out_data_i.status));
          check_field("peak_pct", 32'(want.peak_pct), 32'(out_data_i.peak_pct));
          check_field("last_window_pct", 32'(want.last_window_pct),
                      32'(out_data_i.last_window_pct));
          check_field("peak_ok", 32'(want.peak_ok), 32'(out_data_i.peak_ok));
          check_field("ok_total", want.ok_total, out_data_i.ok_total);
          check_field("skip_total", want.skip_total, out_data_i.skip_total);
        end
      end
      if (cfg_we_i) begin
        peak_cap = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        want = predict_report(in_data_i);
        seen[want.status] = 1'b1;
        reports_due.push_back(want);
      end
    end
    fail_cnt_o <= fails;
    outstanding_o <= unsigned'(reports_due.size());
    checked_cnt_o <= checked;
    status_seen_o <= seen[5:0];
  end

endmodule

// ----- dv/cpu_load_idle_delta_monitor_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu_load_idle_delta_monitor_test
// Drives directed and random counter samples and peak clears into the cpu
// load monitor under several peak limits, with random idling on both sides
// and long result stalls; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module cpu_load_idle_delta_monitor_test;

  localparam int unsigned CycleLimit = 400_000;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  clidm_pkg::in_t                in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  clidm_pkg::out_t               out_data;
  logic                          cfg_we = 1'b0;
  logic [clidm_pkg::PctBits-1:0] cfg_data = '0;

  int unsigned fail_cnt;
  int unsigned outstanding;
  int unsigned checked_cnt;
  logic [5:0]  status_seen;

  int unsigned cycle_cnt = 0;
  int unsigned req_cnt = 0;
  bit          no_idle = 1'b0;
  bit          long_hold_req = 1'b0;
  logic [31:0] cur_total = '0;
  logic [31:0] cur_idle = '0;

  cpu_load_idle_delta_monitor dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  clidm_load_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .fail_cnt_o    (fail_cnt),
    .outstanding_o (outstanding),
    .checked_cnt_o (checked_cnt),
    .status_seen_o (status_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, outstanding);
      $display("** cpu_load_idle_delta_monitor: FAILED **");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 45) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(3, 1);
    end
    if (r < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_span();
    case ($urandom_range(7))
      0, 1, 2, 3: begin
        return $urandom_range(2000, 1);
      end
      4, 5: begin
        return $urandom_range(32'h00FF_FFFF, 1);
      end
      6: begin
        return $urandom_range(32'hFFFF_FFFF, 1);
      end
      default: begin
        return 32'hFFFF_FFFF - $urandom_range(15);
      end
    endcase
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned run_left;
    hold_left = 0;
    run_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (run_left != 0 || no_idle) begin
        if (run_left != 0) begin
          run_left--;
        end
        out_ready <= 1'b1;
      end else begin
        hold_left = idle_gap();
        run_left = $urandom_range(24, 1);
        if (hold_left != 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else begin
          run_left--;
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_req(input clidm_pkg::in_t req);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    req_cnt++;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_req(logic func, logic snap, logic [31:0] tot, logic [31:0] idl);
    clidm_pkg::in_t req;
    req.func = func;
    req.snapshot_ok = snap;
    req.total_count = tot;
    req.idle_count = idl;
    send_req(req);
  endtask

  // well-formed sample: both counters move on from the stored baseline
  task automatic advance(logic [31:0] d_total, logic [31:0] d_idle);
    cur_total += d_total;
    cur_idle += d_idle;
    put_req(clidm_pkg::FUNC_SAMPLE, 1'b1, cur_total, cur_idle);
  endtask

  task automatic random_request();
    int unsigned pick;
    logic [31:0] dt;
    logic [31:0] di;
    pick = $urandom_range(99);
    dt = pick_span();
    if (pick < 4) begin
      put_req(clidm_pkg::FUNC_PEAK_CLR, 1'($urandom), $urandom, $urandom);
    end else if (pick < 9) begin
      put_req(clidm_pkg::FUNC_SAMPLE, 1'b0, $urandom, $urandom);
    end else if (pick < 13) begin
      put_req(clidm_pkg::FUNC_SAMPLE, 1'b1, cur_total, cur_idle + $urandom);
    end else if (pick < 18) begin
      // idle moved further than total
      dt = $urandom_range(32'h00FF_FFFF, 1);
      advance(dt, $urandom_range(32'hFFFF_FFFF, dt + 1));
    end else if (pick < 21) begin
      cur_total = $urandom;
      cur_idle = $urandom;
      put_req(clidm_pkg::FUNC_SAMPLE, 1'b1, cur_total, cur_idle);
    end else begin
      case ($urandom_range(5))
        0: di = '0;
        1: di = dt;
        2: di = dt - 1;
        default: di = $urandom_range(dt);
      endcase
      advance(dt, di);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_limit(logic [clidm_pkg::PctBits-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [clidm_pkg::PctBits-1:0] limits[5];
    int unsigned                   directed_cnt;
    limits = '{7'd0, 7'd127, 7'd50, 7'd100, 7'd0};
    limits[4] = clidm_pkg::PctBits'($urandom_range(99, 1));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, limit still at its reset value
    put_req(clidm_pkg::FUNC_PEAK_CLR, 1'b0, '1, '1);
    put_req(clidm_pkg::FUNC_SAMPLE, 1'b0, 32'h1234_5678, '0);
    cur_total = 32'hFFFF_FFF0;
    cur_idle = 32'hFFFF_FF00;
    put_req(clidm_pkg::FUNC_SAMPLE, 1'b1, cur_total, cur_idle);
    put_req(clidm_pkg::FUNC_SAMPLE, 1'b1, cur_total, cur_idle + 5);
    advance(32'h20, 32'h10);
    advance(1000, 0);
    advance(500, 500);
    advance(10, 20);
    advance(3, 2);
    advance('1, '0);
    advance('1, 32'hFFFF_FFFE);
    advance('1, 1);
    advance(7, 3);
    put_req(clidm_pkg::FUNC_SAMPLE, 1'b0, ~cur_total, ~cur_idle);
    put_req(clidm_pkg::FUNC_PEAK_CLR, 1'b1, cur_total, cur_idle);
    advance(1, 0);
    advance(1, 1);
    advance(200, 199);
    put_req(clidm_pkg::FUNC_PEAK_CLR, 1'b0, '0, '0);
    advance(32'h8000_0000, 32'h7FFF_FFFF);
    put_req(clidm_pkg::FUNC_SAMPLE, 1'b1, cur_total, 32'hFFFF_FFFF);
    directed_cnt = req_cnt;

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_limit(limits[ph]);
      no_idle = (ph == 3);
      if (ph == 1 || ph == 3) begin
        long_hold_req = 1'b1;
      end
      repeat (100) random_request();
    end
    drain();

    $display("%0d requests (%0d directed), %0d results compared, %0d left over",
             req_cnt, directed_cnt, checked_cnt, outstanding);
    $display("status codes hit %06b; peak limits 100, 0, 127, 50, 100, %0d",
             status_seen, limits[4]);
    if (fail_cnt == 0 && outstanding == 0) begin
      $display("** cpu_load_idle_delta_monitor: PASSED **");
    end else begin
      $display("** cpu_load_idle_delta_monitor: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/clidm_pkg.sv
rtl/core/clidm_sub.sv
rtl/core/clidm_core.sv
rtl/core/cpu_load_idle_delta_monitor.sv
dv/clidm_load_checker.sv
dv/cpu_load_idle_delta_monitor_test.sv
